// ===== hdl/pcvc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcvc_pkg: shared types and helpers for contact push velocity correction
// Item structs, lane configuration, pipeline advance group, register
// indexes and the signed 32-bit saturation helper.
// ----------------------------------------------------------------------------
package pcvc_pkg;

    // fixed-point fraction bits of all Q values
    localparam int FRAC_BITS = 16;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_FRAME_TIME      = 3'd0,
        CFG_INV_FRAME_TIME  = 3'd1,
        CFG_VELOCITY_LIMIT  = 3'd2,
        CFG_VELOCITY_GAIN   = 3'd3,
        CFG_DEADBAND_HORIZ  = 3'd4,
        CFG_DEADBAND_VERT   = 3'd5,
        CFG_GROUND_THRESH   = 3'd6
    } t_cfg_index;

    // one input item: one body on three axes
    typedef struct packed {
        logic signed [31:0] least_push_x;
        logic signed [31:0] least_push_y;
        logic signed [31:0] least_push_z;
        logic signed [31:0] greatest_push_x;
        logic signed [31:0] greatest_push_y;
        logic signed [31:0] greatest_push_z;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
        logic signed [31:0] speed_x;
        logic signed [31:0] speed_y;
        logic signed [31:0] speed_z;
    } t_pcvc_in;

    // one result item
    typedef struct packed {
        logic signed [31:0] step_x;
        logic signed [31:0] step_y;
        logic signed [31:0] step_z;
        logic signed [31:0] new_speed_x;
        logic signed [31:0] new_speed_y;
        logic signed [31:0] new_speed_z;
        logic               grounded;
    } t_pcvc_out;

    // per-lane view of the configuration
    typedef struct packed {
        logic [30:0] frame_time;
        logic [30:0] inv_frame_time;
        logic [30:0] velocity_limit;
        logic [16:0] velocity_gain;
        logic [30:0] deadband;
    } t_pcvc_lane_cfg;

    // load enables of the four lane stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_pcvc_adv;

    // saturate to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7fff_ffff) begin
            r = 32'sh7fff_ffff;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/pcvc_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcvc_lane: one axis of the velocity correction
// Four register stages: push sum times reciprocal frame time, clamp to the
// velocity limit, step and gain products, saturation. The deadband snap is
// resolved on the stage-four registers and captured by the output register.
// ----------------------------------------------------------------------------
module pcvc_lane (
    input  logic                     i_clk,
    input  pcvc_pkg::t_pcvc_adv      i_adv,
    input  pcvc_pkg::t_pcvc_lane_cfg i_cfg,
    input  logic signed [31:0]       i_least,
    input  logic signed [31:0]       i_greatest,
    input  logic signed [31:0]       i_offset,
    input  logic signed [31:0]       i_speed,
    output logic signed [31:0]       o_step,
    output logic signed [31:0]       o_new_speed
);

    // stage 1: clipped push sum times reciprocal frame time
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [32:0] sum_wide;
    logic signed [31:0] sum;
    logic signed [63:0] n_prod1;
    logic signed [63:0] r_prod1;
    logic signed [31:0] r_off1, r_spd1;

    assign lo       = i_least[31] ? i_least : 32'sd0;
    assign hi       = i_greatest[31] ? 32'sd0 : i_greatest;
    assign sum_wide = 33'(lo) + 33'(hi);
    assign sum      = sum_wide[31:0];   // fits: lo <= 0 <= hi
    assign n_prod1  = sum * $signed({1'b0, i_cfg.inv_frame_time});

    always_ff @(posedge i_clk) begin
        if (i_adv.s1) begin
            r_prod1 <= n_prod1;
            r_off1  <= i_offset;
            r_spd1  <= i_speed;
        end
    end

    // stage 2: scale back and clamp to +/- velocity limit
    logic signed [63:0] corr_full;
    logic signed [63:0] lim_wide;
    logic signed [31:0] lim;
    logic signed [31:0] n_corr;
    logic signed [31:0] r_corr;
    logic signed [31:0] r_off2, r_spd2;

    assign corr_full = r_prod1 >>> pcvc_pkg::FRAC_BITS;
    assign lim_wide  = $signed({33'd0, i_cfg.velocity_limit});
    assign lim       = $signed({1'b0, i_cfg.velocity_limit});

    always_comb begin
        if (corr_full > lim_wide) begin
            n_corr = lim;
        end else if (corr_full < -lim_wide) begin
            n_corr = -lim;
        end else begin
            n_corr = corr_full[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s2) begin
            r_corr <= n_corr;
            r_off2 <= r_off1;
            r_spd2 <= r_spd1;
        end
    end

    // stage 3: correction times frame time and times gain
    logic signed [62:0] n_pft;
    logic signed [48:0] n_pgain;
    logic signed [62:0] r_pft;
    logic signed [48:0] r_pgain;
    logic signed [31:0] r_off3, r_spd3;

    assign n_pft   = r_corr * $signed({1'b0, i_cfg.frame_time});
    assign n_pgain = r_corr * $signed({15'd0, i_cfg.velocity_gain});

    always_ff @(posedge i_clk) begin
        if (i_adv.s3) begin
            r_pft   <= n_pft;
            r_pgain <= n_pgain;
            r_off3  <= r_off2;
            r_spd3  <= r_spd2;
        end
    end

    // stage 4: saturated step and updated speed
    logic signed [63:0] step_full;
    logic signed [63:0] spd_full;
    logic signed [31:0] r_step4, r_nspd4, r_off4;

    assign step_full = 64'(r_pft >>> pcvc_pkg::FRAC_BITS);
    assign spd_full  = 64'(r_spd3) + 64'(r_pgain >>> pcvc_pkg::FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (i_adv.s4) begin
            r_step4 <= pcvc_pkg::sat32(step_full);
            r_nspd4 <= pcvc_pkg::sat32(spd_full);
            r_off4  <= r_off3;
        end
    end

    // deadband snap: return to the previous position, halve the speed
    logic signed [33:0] moved;
    logic signed [33:0] db;
    logic               snap;
    logic signed [31:0] neg_off;

    assign moved   = 34'(r_off4) + 34'(r_step4);
    assign db      = $signed({3'd0, i_cfg.deadband});
    assign snap    = (moved < db) && (moved > -db);
    assign neg_off = (r_off4 == 32'sh8000_0000) ? 32'sh7fff_ffff : -r_off4;

    assign o_step      = snap ? neg_off : r_step4;
    assign o_new_speed = snap ? (r_nspd4 >>> 1) : r_nspd4;

endmodule

// ===== hdl/contact_push_velocity_correct_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contact_push_velocity_correct_top: per-body contact velocity correction
// Three axis lanes, the grounded test and the output register that merges
// them into one result item; configuration register file.
// ----------------------------------------------------------------------------
// One body is taken per clock while input ready is high; the edge that
// accepts it loads the first of the four lane stages, the item moves on
// through the second, third and fourth, and then loads the output register.
// The stage count is set by the multiplier pipeline in each axis lane:
// the reciprocal product, the clamp, the step and gain products and the
// saturation each get a stage. Stages that hold no item let new items in while
// a result waits at the output, so input ready drops only when every stage is
// full and the output is not taken. Configuration writes are always accepted
// and take effect on the next clock; write only while no item is in flight.
module contact_push_velocity_correct_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pcvc_pkg::t_pcvc_in  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pcvc_pkg::t_pcvc_out o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    // configuration registers
    logic [30:0]        r_frame_time, r_inv_frame_time, r_velocity_limit;
    logic [16:0]        r_velocity_gain;
    logic [30:0]        r_deadband_h, r_deadband_v;
    logic signed [31:0] r_ground_thr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_time     <= 31'd1092;
            r_inv_frame_time <= 31'd3932160;
            r_velocity_limit <= 31'd26214400;
            r_velocity_gain  <= 17'd1966;
            r_deadband_h     <= 31'd328;
            r_deadband_v     <= 31'd131;
            r_ground_thr     <= 32'sd1966;
        end else if (i_cfg_valid) begin
            case (pcvc_pkg::t_cfg_index'(i_cfg_index))
                pcvc_pkg::CFG_FRAME_TIME:     r_frame_time     <= i_cfg_data[30:0];
                pcvc_pkg::CFG_INV_FRAME_TIME: r_inv_frame_time <= i_cfg_data[30:0];
                pcvc_pkg::CFG_VELOCITY_LIMIT: r_velocity_limit <= i_cfg_data[30:0];
                pcvc_pkg::CFG_VELOCITY_GAIN:  r_velocity_gain  <= i_cfg_data[16:0];
                pcvc_pkg::CFG_DEADBAND_HORIZ: r_deadband_h     <= i_cfg_data[30:0];
                pcvc_pkg::CFG_DEADBAND_VERT:  r_deadband_v     <= i_cfg_data[30:0];
                pcvc_pkg::CFG_GROUND_THRESH:  r_ground_thr     <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // pipeline control: a stage loads when it is empty or moving on
    logic [4:1]          r_vld;
    logic                en_out;
    pcvc_pkg::t_pcvc_adv adv;

    assign en_out     = !o_out_valid || i_out_ready;
    assign adv.s4     = !r_vld[4] || en_out;
    assign adv.s3     = !r_vld[3] || adv.s4;
    assign adv.s2     = !r_vld[2] || adv.s3;
    assign adv.s1     = !r_vld[1] || adv.s2;
    assign o_in_ready = adv.s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (adv.s1) r_vld[1] <= i_in_valid;
            if (adv.s2) r_vld[2] <= r_vld[1];
            if (adv.s3) r_vld[3] <= r_vld[2];
            if (adv.s4) r_vld[4] <= r_vld[3];
            if (en_out) o_out_valid <= r_vld[4];
        end
    end

    // grounded test on the clipped least y push, carried alongside the lanes
    logic signed [31:0] clipped_y;
    logic [4:1]         r_gnd;

    assign clipped_y = i_in_item.least_push_y[31] ? i_in_item.least_push_y : 32'sd0;

    always_ff @(posedge i_clk) begin
        if (adv.s1) r_gnd[1] <= (clipped_y < r_ground_thr);
        if (adv.s2) r_gnd[2] <= r_gnd[1];
        if (adv.s3) r_gnd[3] <= r_gnd[2];
        if (adv.s4) r_gnd[4] <= r_gnd[3];
    end

    // lane configuration
    pcvc_pkg::t_pcvc_lane_cfg cfg_h, cfg_v;

    assign cfg_h = '{frame_time:     r_frame_time,
                     inv_frame_time: r_inv_frame_time,
                     velocity_limit: r_velocity_limit,
                     velocity_gain:  r_velocity_gain,
                     deadband:       r_deadband_h};
    assign cfg_v = '{frame_time:     r_frame_time,
                     inv_frame_time: r_inv_frame_time,
                     velocity_limit: r_velocity_limit,
                     velocity_gain:  r_velocity_gain,
                     deadband:       r_deadband_v};

    // axis lanes
    logic signed [31:0] step_x, step_y, step_z;
    logic signed [31:0] nspd_x, nspd_y, nspd_z;

    pcvc_lane u_lane_x (
        .i_clk       (i_clk),
        .i_adv       (adv),
        .i_cfg       (cfg_h),
        .i_least     (i_in_item.least_push_x),
        .i_greatest  (i_in_item.greatest_push_x),
        .i_offset    (i_in_item.offset_x),
        .i_speed     (i_in_item.speed_x),
        .o_step      (step_x),
        .o_new_speed (nspd_x)
    );

    pcvc_lane u_lane_y (
        .i_clk       (i_clk),
        .i_adv       (adv),
        .i_cfg       (cfg_v),
        .i_least     (i_in_item.least_push_y),
        .i_greatest  (i_in_item.greatest_push_y),
        .i_offset    (i_in_item.offset_y),
        .i_speed     (i_in_item.speed_y),
        .o_step      (step_y),
        .o_new_speed (nspd_y)
    );

    pcvc_lane u_lane_z (
        .i_clk       (i_clk),
        .i_adv       (adv),
        .i_cfg       (cfg_h),
        .i_least     (i_in_item.least_push_z),
        .i_greatest  (i_in_item.greatest_push_z),
        .i_offset    (i_in_item.offset_z),
        .i_speed     (i_in_item.speed_z),
        .o_step      (step_z),
        .o_new_speed (nspd_z)
    );

    // merge lanes into the output register
    always_ff @(posedge i_clk) begin
        if (en_out) begin
            o_out_item.step_x      <= step_x;
            o_out_item.step_y      <= step_y;
            o_out_item.step_z      <= step_z;
            o_out_item.new_speed_x <= nspd_x;
            o_out_item.new_speed_y <= nspd_y;
            o_out_item.new_speed_z <= nspd_z;
            o_out_item.grounded    <= r_gnd[4];
        end
    end

    // a free output register never blocks the input
    a_ready_when_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with the output register free");

    // first stage holds an item only if one was accepted or it was held
    a_stage1_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_vld[1]) |-> $past(i_in_valid && o_in_ready))
        else $error("first stage became valid without an accepted item");

    // with a positive threshold every body counts as grounded
    a_grounded_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_ground_thr > 32'sd0)) |-> o_out_item.grounded)
        else $error("grounded flag low with a positive threshold");

endmodule
